// ===== src/vectorscope_line_rasterizer_defines.svh =====
// Assertion shorthands shared by the rasterizer modules.
`ifndef VECTORSCOPE_LINE_RASTERIZER_DEFINES_SVH
`define VECTORSCOPE_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define VLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define VLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vlr_pkg.sv =====
package vlr_pkg;

	localparam int SAMPLE_W   = 18;
	localparam int MAG_W      = SAMPLE_W + 1;
	localparam int PIX_W      = 7;
	localparam int PROD_W     = MAG_W + PIX_W;
	localparam int DIV_STEPS  = PIX_W;
	localparam int DIV_IDX_W  = 3;
	localparam int MAX_PIXELS = 63;
	localparam int CNT_W      = 6;
	localparam int ERR_W      = PIX_W + 1;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;
	localparam logic [SAMPLE_W-1:0] ONE_Q14 = SAMPLE_W'(16384);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_CLAMP,
		ST_SETUP,
		ST_DRAW
	} vlr_state_t;

	typedef struct packed {
		logic                 load;
		logic                 mul;
		logic                 div_step;
		logic [DIV_IDX_W-1:0] div_shift;
		logic                 clamp;
		logic                 setup;
		logic                 advance;
	} vlr_cmd_t;

	typedef struct packed {
		logic drop;
		logic last;
	} vlr_status_t;

endpackage

// ===== src/vectorscope_line_rasterizer.sv =====
// Channel   Direction  tdata (low bit up)                        tuser / tlast
// s_axis    in         east_west_sample[17:0], north_south_sample  tuser: efield_negative
// m_axis    out        pixel_column[6:0], pixel_row[6:0]           tlast: last_pixel
// cfg       in         cfg_wdata: efield_enable, written on cfg_we
//
// An item passes through an accept state, a multiply state, seven steps of the shared
// restoring divider, a clamp state and a setup state, then the Bresenham stepper gives
// one pixel per cycle while m_axis is ready; a line has 1 to 63 pixels.
// A dropped item is accepted and discarded, and the controller stays idle.
// Reset clears the controller and the efield_enable register; line registers need none.
// A stall on m_axis holds the current pixel; no new item is taken until the last pixel leaves.
module vectorscope_line_rasterizer #(
	parameter int IMAGE_SIZE = 124
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: east_west_sample (18), north_south_sample (18), zero fill (4).
	input  logic [vlr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// Fields from bit 0: efield_negative (1).
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// Fields from bit 0: pixel_column (7), pixel_row (7), zero fill (2).
	output logic [vlr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast
);
	import vlr_pkg::*;

	// The controller sequences the datapath through commands and only sees
	// two status bits back: whether the offered item is dropped and whether the
	// pixel on the output is the last of its line.
	vlr_cmd_t    cmd;
	vlr_status_t status;

	vlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the samples, the two division lanes, and the line
	// stepper whose registers drive the output beat directly.
	vlr_datapath #(
		.IMAGE_SIZE (IMAGE_SIZE)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_data            (s_axis_tdata),
		.in_efield_negative (s_axis_tuser),
		.cmd                (cmd),
		.status             (status),
		.out_data           (m_axis_tdata),
		.out_last           (m_axis_tlast)
	);

endmodule

// ===== src/vlr_ctrl.sv =====
`include "vectorscope_line_rasterizer_defines.svh"

module vlr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  vlr_pkg::vlr_status_t status,
	output vlr_pkg::vlr_cmd_t    cmd
);
	import vlr_pkg::*;

	vlr_state_t           state_q, state_d;
	logic [DIV_IDX_W-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				div_cnt_q <= DIV_IDX_W'(DIV_STEPS - 1);
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !status.drop) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_DRAW;
			ST_DRAW: begin
				if (out_ready && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd           = '0;
		cmd.div_shift = div_cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_SETUP: cmd.setup = 1'b1;
			ST_DRAW: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready;
			end
			default: ;
		endcase
	end

	`VLR_ASSERT_NOW(a_one_side, clk, arst_n, in_ready, !out_valid, "input and output both open")
	`VLR_ASSERT_NEXT(a_div_done, clk, arst_n, (state_q == ST_DIV) && (div_cnt_q == '0), state_q == ST_CLAMP, "division did not end after its last step")
	`VLR_ASSERT_NEXT(a_last_beat, clk, arst_n, out_valid && out_ready && status.last, in_ready, "not idle after the last pixel")

endmodule

// ===== src/vlr_datapath.sv =====
`include "vectorscope_line_rasterizer_defines.svh"

module vlr_datapath #(
	parameter int IMAGE_SIZE = 124
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic [vlr_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                               in_efield_negative,
	input  vlr_pkg::vlr_cmd_t                  cmd,
	output vlr_pkg::vlr_status_t               status,
	output logic [vlr_pkg::OUT_DATA_W-1:0]     out_data,
	output logic                               out_last
);
	import vlr_pkg::*;

	localparam logic [PIX_W-1:0] CENTRE   = PIX_W'(IMAGE_SIZE / 2);
	localparam logic [PIX_W-1:0] LAST_IDX = PIX_W'(IMAGE_SIZE - 1);
	localparam logic [PROD_W-1:0] SIZE_P  = PROD_W'(IMAGE_SIZE);

	logic efield_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			efield_enable_q <= 1'b0;
		end else if (cfg_we) begin
			efield_enable_q <= cfg_wdata;
		end
	end

	assign status.drop = efield_enable_q && in_efield_negative;

	// Sample capture, magnitude and effective scale.
	logic signed [SAMPLE_W-1:0] ew_in, ns_in, ew_q, ns_q;
	logic [SAMPLE_W-1:0]        aew, ans, mag, meff, meff_q;

	assign ew_in = $signed(in_data[SAMPLE_W-1:0]);
	assign ns_in = $signed(in_data[2*SAMPLE_W-1:SAMPLE_W]);
	assign aew   = ew_in[SAMPLE_W-1] ? SAMPLE_W'(-ew_in) : SAMPLE_W'(ew_in);
	assign ans   = ns_in[SAMPLE_W-1] ? SAMPLE_W'(-ns_in) : SAMPLE_W'(ns_in);
	assign mag   = (aew > ans) ? aew : ans;
	assign meff  = (mag < ONE_Q14) ? ONE_Q14 : mag;

	// Numerators scale*(meff+v), then a shared restoring division by 2*meff.
	logic signed [MAG_W:0]  sum_ew, sum_ns;
	logic [PROD_W-1:0]      rem_ew_q, rem_ns_q, den_sh;
	logic [MAG_W-1:0]       den_q;
	logic [PIX_W-1:0]       q_ew_q, q_ns_q;

	assign sum_ew = $signed({2'b00, meff_q}) + (MAG_W + 1)'(ew_q);
	assign sum_ns = $signed({2'b00, meff_q}) + (MAG_W + 1)'(ns_q);
	assign den_sh = PROD_W'(den_q) << cmd.div_shift;

	// Line state.
	logic [PIX_W-1:0]        e1_q, e2_q;
	logic [PIX_W-1:0]        adx, ady, a1, b1, xs, ys, xe, ye, dmaj, dmin;
	logic                    steep;
	logic [PIX_W-1:0]        x_q, y_q, xend_q, dmaj_q, dmin_q;
	logic signed [ERR_W-1:0] err_q, err_sub, err_next;
	logic                    steep_q, up_q;
	logic [CNT_W-1:0]        cnt_q;

	assign adx   = (e1_q >= CENTRE) ? e1_q - CENTRE : CENTRE - e1_q;
	assign ady   = (e2_q >= CENTRE) ? e2_q - CENTRE : CENTRE - e2_q;
	assign steep = ady > adx;
	assign a1    = steep ? e2_q : e1_q;
	assign b1    = steep ? e1_q : e2_q;

	always_comb begin
		if (a1 < CENTRE) begin
			xs = a1;
			ys = b1;
			xe = CENTRE;
			ye = CENTRE;
		end else begin
			xs = CENTRE;
			ys = CENTRE;
			xe = a1;
			ye = b1;
		end
		dmaj = xe - xs;
		dmin = (ye >= ys) ? ye - ys : ys - ye;
	end

	assign err_sub  = err_q - $signed(ERR_W'(dmin_q));
	assign err_next = err_sub[ERR_W-1] ? err_sub + $signed(ERR_W'(dmaj_q)) : err_sub;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ew_q   <= ew_in;
			ns_q   <= ns_in;
			meff_q <= meff;
		end
		if (cmd.mul) begin
			rem_ew_q <= PROD_W'(sum_ew[MAG_W-1:0]) * SIZE_P;
			rem_ns_q <= PROD_W'(sum_ns[MAG_W-1:0]) * SIZE_P;
			den_q    <= {meff_q, 1'b0};
			q_ew_q   <= '0;
			q_ns_q   <= '0;
		end
		if (cmd.div_step) begin
			if (rem_ew_q >= den_sh) begin
				rem_ew_q <= rem_ew_q - den_sh;
				q_ew_q   <= {q_ew_q[PIX_W-2:0], 1'b1};
			end else begin
				q_ew_q <= {q_ew_q[PIX_W-2:0], 1'b0};
			end
			if (rem_ns_q >= den_sh) begin
				rem_ns_q <= rem_ns_q - den_sh;
				q_ns_q   <= {q_ns_q[PIX_W-2:0], 1'b1};
			end else begin
				q_ns_q <= {q_ns_q[PIX_W-2:0], 1'b0};
			end
		end
		if (cmd.clamp) begin
			e1_q <= (q_ew_q > LAST_IDX) ? LAST_IDX : q_ew_q;
			e2_q <= (q_ns_q > LAST_IDX) ? LAST_IDX : q_ns_q;
		end
		if (cmd.setup) begin
			x_q     <= xs;
			y_q     <= ys;
			xend_q  <= xe;
			dmaj_q  <= dmaj;
			dmin_q  <= dmin;
			err_q   <= $signed(ERR_W'(dmaj >> 1));
			steep_q <= steep;
			up_q    <= ys < ye;
			cnt_q   <= '0;
		end
		if (cmd.advance) begin
			x_q   <= x_q + 1'b1;
			err_q <= err_next;
			cnt_q <= cnt_q + 1'b1;
			if (err_sub[ERR_W-1]) begin
				y_q <= up_q ? y_q + 1'b1 : y_q - 1'b1;
			end
		end
	end

	assign status.last = (x_q == xend_q) || (cnt_q == CNT_W'(MAX_PIXELS - 1));
	assign out_last    = status.last;
	assign out_data    = {2'b00, (steep_q ? x_q : y_q), (steep_q ? y_q : x_q)};

	`VLR_ASSERT_NEXT(a_clamped, clk, arst_n, cmd.clamp, (e1_q <= LAST_IDX) && (e2_q <= LAST_IDX), "endpoint outside the image")
	`VLR_ASSERT_NEXT(a_err_pos, clk, arst_n, cmd.advance, !err_q[ERR_W-1], "error term negative after a step")
	`VLR_ASSERT_NEXT(a_major_step, clk, arst_n, cmd.advance && !status.last, x_q == $past(x_q) + 1'b1, "major coordinate did not advance by one")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the vectorscope line rasterizer. A sample pair goes in on s_axis, and the
// block answers with the pixels of a line from the image center to the mapped point.
// Each accepted input beat is run through a predictor here, which queues the pixels the
// line should light. Each accepted output beat is checked against the oldest of those.
// Both streams idle at random. The E-field drop register is switched between phases,
// always with the block drained.
module tb_top;

	import vlr_pkg::*;

	localparam int IMG          = 124;
	localparam int CENTER       = IMG / 2;
	// Longer than the slowest item, which runs every setup state and then draws 63 pixels.
	localparam int SETTLE_CYCLES = 90;
	// The number of cycles with no beat on either side that is taken as a hang.
	localparam int HANG_LIMIT   = 5000;

	// One lit pixel as the output stream carries it.
	typedef struct packed {
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic             last;
	} pixel_t;

	// Predicts the pixels of each line and checks them in order as they come out.
	class line_pixel_scoreboard;
		bit     efield_en;
		pixel_t pending[$];
		int     mismatches;

		function new();
			efield_en = 1'b0;
			mismatches = 0;
		endfunction

		// Maps a sample to a pixel index, after scaling by the larger magnitude if that
		// magnitude is above 1.0.
		function int axis_pixel(int v, int m);
			longint num;
			longint den;
			longint q;
			if (m <= 16384) begin
				num = longint'(IMG) * (16384 + v);
				den = 32768;
			end else begin
				num = longint'(IMG) * (m + v);
				den = 2 * longint'(m);
			end
			q = num / den;
			if (q > IMG - 1)
				q = IMG - 1;
			return int'(q);
		endfunction

		// Notes an accepted sample pair and queues the pixels of its line.
		function void note_input(logic signed [SAMPLE_W-1:0] ew, logic signed [SAMPLE_W-1:0] ns,
				logic eneg);
			int     aew, ans, m, end_col, end_row;
			int     maj0, maj1, min0, min1, t, span_maj, span_min, err, minor, step, k, n;
			bit     steep;
			pixel_t px;
			if (efield_en && eneg)
				return;
			aew = (ew < 0) ? -int'(ew) : int'(ew);
			ans = (ns < 0) ? -int'(ns) : int'(ns);
			m = (aew > ans) ? aew : ans;
			end_col = axis_pixel(int'(ew), m);
			end_row = axis_pixel(int'(ns), m);

			// The major axis is the one with the longer span from the center.
			steep = ((end_row > CENTER ? end_row - CENTER : CENTER - end_row) >
				(end_col > CENTER ? end_col - CENTER : CENTER - end_col));
			maj0 = CENTER;
			min0 = CENTER;
			maj1 = steep ? end_row : end_col;
			min1 = steep ? end_col : end_row;
			// The line is always walked toward increasing major coordinate.
			if (maj0 > maj1) begin
				t = maj0; maj0 = maj1; maj1 = t;
				t = min0; min0 = min1; min1 = t;
			end
			span_maj = maj1 - maj0;
			span_min = (min1 > min0) ? min1 - min0 : min0 - min1;
			err = span_maj / 2;
			minor = min0;
			step = (min0 < min1) ? 1 : -1;
			n = 0;
			for (k = maj0; k <= maj1 && n < MAX_PIXELS; k++) begin
				px.col = PIX_W'(steep ? minor : k);
				px.row = PIX_W'(steep ? k : minor);
				px.last = (k == maj1) || (n == MAX_PIXELS - 1);
				pending.push_back(px);
				n++;
				err -= span_min;
				if (err < 0) begin
					minor += step;
					err += span_maj;
				end
			end
		endfunction

		// Checks one output beat against the oldest pending pixel.
		function void check_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row, logic last);
			pixel_t want;
			if (pending.size() == 0) begin
				$error("pixel beat col %0d row %0d last %0b with no pixel pending", col, row, last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (col !== want.col) begin
				$error("pixel_column: expected %0d, got %0d", want.col, col);
				mismatches++;
			end
			if (row !== want.row) begin
				$error("pixel_row: expected %0d, got %0d", want.row, row);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_pixel: expected %0b, got %0b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// Fields from bit 0: east_west_sample (18), north_south_sample (18), zero fill (4).
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// Fields from bit 0: efield_negative (1).
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// Fields from bit 0: pixel_column (7), pixel_row (7), zero fill (2).
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	line_pixel_scoreboard lines;
	int                   hang_count;
	// When set, the sender sends beats back to back with no gaps.
	bit                   tx_steady;

	vectorscope_line_rasterizer #(
		.IMAGE_SIZE(IMG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length for either side. Most gaps are short, and a few are long.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// A random Q3.14 sample. Most fall inside the unit range, some span all 18 bits, and
	// some sit on the full-scale and overflow edges where the scaling and clamp act.
	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return SAMPLE_W'($urandom_range(0, 32768) - 16384);
		else if (r < 75)
			return SAMPLE_W'($urandom);
		else if (r < 87)
			return SAMPLE_W'($urandom_range(0, 64) - 32);
		else begin
			case ($urandom_range(0, 6))
				0: return SAMPLE_W'(-131072);
				1: return SAMPLE_W'(131071);
				2: return SAMPLE_W'(16384);
				3: return SAMPLE_W'(-16384);
				4: return SAMPLE_W'(16385);
				5: return SAMPLE_W'(-16385);
				default: return '0;
			endcase
		end
	endfunction

	// Sends one sample pair and returns in the time step of the edge that takes it.
	// It is called from a rising edge step, so valid is raised at most once per step.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] ew,
			input logic signed [SAMPLE_W-1:0] ns, input logic eneg);
		int gap;
		gap = tx_steady ? 0 : gap_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, ns, ew};
		s_axis_tuser <= eneg;
		// Handshakes are judged at the falling edge, where every signal is settled.
		do
			@(negedge clk);
		while (!s_axis_tready);
		lines.note_input(ew, ns, eneg);
		@(posedge clk);
	endtask

	// Stops the sender and waits until every pixel has left and the block is quiet.
	task automatic drain_lines();
		s_axis_tvalid <= 1'b0;
		while (lines.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the drop register. The block must be drained first.
	task automatic write_efield_enable(input logic value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lines.efield_en = value;
	endtask

	task automatic random_lines(input int count);
		for (int i = 0; i < count; i++) begin
			// Every few dozen beats, run a stretch with no gaps.
			tx_steady = (i % 60) >= 45;
			send_sample(random_sample(), random_sample(), 1'($urandom));
		end
		tx_steady = 1'b0;
	endtask

	// The receiver alternates runs of ready with stalls, and some runs are long.
	initial begin
		int run;
		m_axis_tready = 1'b0;
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (run) begin
				@(posedge clk);
				m_axis_tready <= 1'b1;
			end
			repeat (gap_cycles()) begin
				@(posedge clk);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// Output checking and hang detection, both at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				lines.check_pixel(m_axis_tdata[PIX_W-1:0], m_axis_tdata[2*PIX_W-1:PIX_W],
					m_axis_tlast);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				hang_count = 0;
			else
				hang_count++;
			if (hang_count >= HANG_LIMIT) begin
				$display("vectorscope_line_rasterizer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		lines = new();
		hang_count = 0;
		tx_steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines with the drop register at its reset value of zero.
		// Both samples are zero, so the line is the center pixel alone.
		send_sample(0, 0, 1'b0);
		// Exactly full scale maps to the image size, which is then clamped.
		send_sample(16384, 16384, 1'b0);
		send_sample(-16384, -16384, 1'b0);
		send_sample(16384, 0, 1'b0);
		send_sample(0, 16384, 1'b0);
		send_sample(-16384, 0, 1'b1);
		send_sample(0, -16384, 1'b1);
		// Overflow, which is scaled back by the larger magnitude.
		send_sample(131071, 0, 1'b0);
		send_sample(-131072, 131071, 1'b0);
		send_sample(-131072, -131072, 1'b1);
		send_sample(131071, -131072, 1'b0);
		send_sample(16385, -3000, 1'b0);
		// Shallow and steep lines toward each quadrant.
		send_sample(8000, 3000, 1'b0);
		send_sample(3000, 8000, 1'b0);
		send_sample(-8000, 3000, 1'b0);
		send_sample(-3000, -8000, 1'b0);
		send_sample(12000, -5000, 1'b0);
		send_sample(1, -1, 1'b0);
		send_sample(-1, 1, 1'b0);
		drain_lines();

		// Once negative E-field samples are dropped, only their twins with a positive
		// E-field draw.
		write_efield_enable(1'b1);
		send_sample(9000, -9000, 1'b1);
		send_sample(9000, -9000, 1'b0);
		send_sample(131071, 131071, 1'b1);
		send_sample(-16384, 16384, 1'b0);
		random_lines(150);
		drain_lines();

		write_efield_enable(1'b0);
		random_lines(150);
		drain_lines();

		write_efield_enable(1'b1);
		random_lines(150);
		drain_lines();

		if (lines.pending.size() != 0) begin
			$error("%0d pixels still pending at the end", lines.pending.size());
			lines.mismatches++;
		end
		if (lines.mismatches == 0)
			$display("vectorscope_line_rasterizer: match");
		else
			$display("vectorscope_line_rasterizer: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/vlr_pkg.sv
src/vlr_ctrl.sv
src/vlr_datapath.sv
src/vectorscope_line_rasterizer.sv
tb/tb_top.sv
